@@ src/qes_pkg.sv @@
`default_nettype none

package qes_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_WORDS     = 12;
  localparam int unsigned ADDR_W        = $clog2(NUM_WORDS);
  localparam int unsigned NUM_FIELDS    = 10;
  localparam int unsigned NUM_TEMPS     = 4;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned CFG_W         = 31;
  localparam int unsigned CFG_IDX_W     = 3;

  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_INER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG      = 3'd5;

  localparam logic [CFG_W-1:0] RST_TIME_STEP = 31'd6554;
  localparam logic [CFG_W-1:0] RST_GRAVITY   = 31'd642908;
  localparam logic [CFG_W-1:0] RST_INV_MASS  = 31'd65536;
  localparam logic [CFG_W-1:0] RST_INV_INER  = 31'd1310720;
  localparam logic [CFG_W-1:0] RST_ARM       = 31'd16384;
  localparam logic [CFG_W-1:0] RST_DRAG      = 31'd6554;

  // state word addresses, in result order
  localparam logic [ADDR_W-1:0] ADDR_PX = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_PY = 4'd1;
  localparam logic [ADDR_W-1:0] ADDR_PZ = 4'd2;
  localparam logic [ADDR_W-1:0] ADDR_VX = 4'd3;
  localparam logic [ADDR_W-1:0] ADDR_VY = 4'd4;
  localparam logic [ADDR_W-1:0] ADDR_VZ = 4'd5;
  localparam logic [ADDR_W-1:0] ADDR_AR = 4'd6;
  localparam logic [ADDR_W-1:0] ADDR_AP = 4'd7;
  localparam logic [ADDR_W-1:0] ADDR_AY = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_RR = 4'd9;
  localparam logic [ADDR_W-1:0] ADDR_RP = 4'd10;
  localparam logic [ADDR_W-1:0] ADDR_RY = 4'd11;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_RAM, SRC_RES,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3,
    SRC_F0, SRC_F1, SRC_F2, SRC_F3, SRC_F4,
    SRC_F5, SRC_F6, SRC_F7, SRC_F8, SRC_F9,
    SRC_DT, SRC_GRAV, SRC_IMASS, SRC_IINER, SRC_ARM, SRC_DRAG
  } src_e;

  localparam int unsigned NUM_SRC = 23;

  typedef enum logic [1:0] {
    POST_NONE, POST_NEG, POST_ADDX, POST_SUBX
  } post_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_T0, DST_T1, DST_T2, DST_T3, DST_RAM
  } dst_e;

  typedef struct packed {
    logic              mul;
    src_e              a;
    src_e              b;
    post_e             post;
    src_e              x;
    dst_e              dst;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } uop_t;

  typedef struct packed {
    logic  mul_en;
    logic  use_mul;
    post_e post;
  } mac_ctrl_t;

  function automatic uop_t mk(logic mul, src_e a, src_e b, post_e p, src_e x, dst_e d,
                              logic [ADDR_W-1:0] addr, logic last);
    uop_t u;
    u.mul  = mul;
    u.a    = a;
    u.b    = b;
    u.post = p;
    u.x    = x;
    u.dst  = d;
    u.addr = addr;
    u.last = last;
    return u;
  endfunction

  // operation list of one tick, per kind
  function automatic uop_t uop_lookup(logic kind, logic [STEP_W-1:0] step);
    uop_t u;
    u = mk(1'b0, SRC_ZERO, SRC_ZERO, POST_NONE, SRC_ZERO, DST_NONE, ADDR_PX, 1'b0);
    if (!kind) begin
      case (step)
        5'd0:  u = mk(1'b0, SRC_F0, SRC_ZERO, POST_ADDX, SRC_F1, DST_T0, ADDR_PX, 1'b0);
        5'd1:  u = mk(1'b0, SRC_T0, SRC_ZERO, POST_ADDX, SRC_F2, DST_T0, ADDR_PX, 1'b0);
        5'd2:  u = mk(1'b0, SRC_T0, SRC_ZERO, POST_ADDX, SRC_F3, DST_T0, ADDR_PX, 1'b0);
        5'd3:  u = mk(1'b0, SRC_F0, SRC_ZERO, POST_SUBX, SRC_F2, DST_T1, ADDR_PX, 1'b0);
        5'd4:  u = mk(1'b0, SRC_F1, SRC_ZERO, POST_SUBX, SRC_F3, DST_T2, ADDR_PX, 1'b0);
        5'd5:  u = mk(1'b1, SRC_T1, SRC_ARM, POST_NONE, SRC_ZERO, DST_T1, ADDR_PX, 1'b0);
        5'd6:  u = mk(1'b1, SRC_T2, SRC_ARM, POST_NONE, SRC_ZERO, DST_T2, ADDR_PX, 1'b0);
        5'd7:  u = mk(1'b1, SRC_T1, SRC_IINER, POST_NONE, SRC_ZERO, DST_T1, ADDR_PX, 1'b0);
        5'd8:  u = mk(1'b1, SRC_T2, SRC_IINER, POST_NONE, SRC_ZERO, DST_T2, ADDR_PX, 1'b0);
        5'd9:  u = mk(1'b1, SRC_DRAG, SRC_RAM, POST_NONE, SRC_ZERO, DST_T3, ADDR_VX, 1'b0);
        5'd10: u = mk(1'b1, SRC_T3, SRC_IMASS, POST_NEG, SRC_ZERO, DST_T3, ADDR_PX, 1'b0);
        5'd11: u = mk(1'b1, SRC_T3, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_VX, 1'b0);
        5'd12: u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_PX, 1'b0);
        5'd13: u = mk(1'b1, SRC_DRAG, SRC_RAM, POST_NONE, SRC_ZERO, DST_T3, ADDR_VY, 1'b0);
        5'd14: u = mk(1'b1, SRC_T3, SRC_IMASS, POST_NEG, SRC_ZERO, DST_T3, ADDR_PX, 1'b0);
        5'd15: u = mk(1'b1, SRC_T3, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_VY, 1'b0);
        5'd16: u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_PY, 1'b0);
        5'd17: u = mk(1'b1, SRC_DRAG, SRC_RAM, POST_NONE, SRC_ZERO, DST_T3, ADDR_VZ, 1'b0);
        5'd18: u = mk(1'b1, SRC_T3, SRC_IMASS, POST_NEG, SRC_ZERO, DST_T3, ADDR_PX, 1'b0);
        5'd19: u = mk(1'b1, SRC_T0, SRC_IMASS, POST_SUBX, SRC_GRAV, DST_T0, ADDR_PX, 1'b0);
        5'd20: u = mk(1'b0, SRC_T0, SRC_ZERO, POST_ADDX, SRC_T3, DST_T0, ADDR_PX, 1'b0);
        5'd21: u = mk(1'b1, SRC_T0, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_VZ, 1'b0);
        5'd22: u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_PZ, 1'b0);
        5'd23: u = mk(1'b1, SRC_T2, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_RR, 1'b0);
        5'd24: u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_AR, 1'b0);
        5'd25: u = mk(1'b1, SRC_T1, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_RP, 1'b0);
        5'd26: u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_AP, 1'b0);
        5'd27: u = mk(1'b0, SRC_RAM, SRC_ZERO, POST_ADDX, SRC_ZERO, DST_NONE, ADDR_RY, 1'b0);
        5'd28: u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_AY, 1'b1);
        default: u = mk(1'b0, SRC_ZERO, SRC_ZERO, POST_NONE, SRC_ZERO, DST_NONE, ADDR_PX,
                        1'b1);
      endcase
    end else begin
      case (step)
        5'd0:  u = mk(1'b1, SRC_F4, SRC_IMASS, POST_NONE, SRC_ZERO, DST_T0, ADDR_PX, 1'b0);
        5'd1:  u = mk(1'b1, SRC_T0, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_VX, 1'b0);
        5'd2:  u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_PX, 1'b0);
        5'd3:  u = mk(1'b1, SRC_F5, SRC_IMASS, POST_NONE, SRC_ZERO, DST_T0, ADDR_VY, 1'b0);
        5'd4:  u = mk(1'b1, SRC_T0, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_VY, 1'b0);
        5'd5:  u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_PY, 1'b0);
        5'd6:  u = mk(1'b1, SRC_F6, SRC_IMASS, POST_SUBX, SRC_GRAV, DST_T0, ADDR_VZ, 1'b0);
        5'd7:  u = mk(1'b1, SRC_T0, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_VZ, 1'b0);
        5'd8:  u = mk(1'b1, SRC_RES, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_PZ, 1'b0);
        5'd9:  u = mk(1'b1, SRC_F7, SRC_IINER, POST_NONE, SRC_ZERO, DST_T0, ADDR_AR, 1'b0);
        5'd10: u = mk(1'b1, SRC_T0, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_AR, 1'b0);
        5'd11: u = mk(1'b1, SRC_F8, SRC_IINER, POST_NONE, SRC_ZERO, DST_T0, ADDR_AP, 1'b0);
        5'd12: u = mk(1'b1, SRC_T0, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_AP, 1'b0);
        5'd13: u = mk(1'b1, SRC_F9, SRC_IINER, POST_NONE, SRC_ZERO, DST_T0, ADDR_AY, 1'b0);
        5'd14: u = mk(1'b1, SRC_T0, SRC_DT, POST_ADDX, SRC_RAM, DST_RAM, ADDR_AY, 1'b1);
        default: u = mk(1'b0, SRC_ZERO, SRC_ZERO, POST_NONE, SRC_ZERO, DST_NONE, ADDR_PX,
                        1'b1);
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

@@ src/qes_ram.sv @@
`default_nettype none

module qes_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/qes_mac.sv @@
`default_nettype none

module qes_mac #(
  parameter int unsigned FRAC_BITS = qes_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire qes_pkg::mac_ctrl_t                ctrl_i,
  input  wire logic signed [qes_pkg::WORD_W-1:0] a_i,
  input  wire logic signed [qes_pkg::WORD_W-1:0] b_i,
  input  wire logic signed [qes_pkg::WORD_W-1:0] x_i,
  output logic      signed [qes_pkg::WORD_W-1:0] res_o
);

  import qes_pkg::*;

  logic signed [2*WORD_W-1:0] prod_q;
  logic signed [2*WORD_W-1:0] shifted;
  logic signed [WORD_W-1:0]   mul_sat;
  logic signed [WORD_W-1:0]   base;
  logic signed [WORD_W:0]     sum;
  logic signed [WORD_W:0]     diff;
  logic                       hi_ones;
  logic                       hi_zeros;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  // floor shift, then clamp to the word range
  assign shifted  = prod_q >>> FRAC_BITS;
  assign hi_ones  = &shifted[2*WORD_W-1:WORD_W-1];
  assign hi_zeros = ~|shifted[2*WORD_W-1:WORD_W-1];

  always_comb begin
    if (hi_ones || hi_zeros) begin
      mul_sat = shifted[WORD_W-1:0];
    end else if (shifted[2*WORD_W-1]) begin
      mul_sat = WMIN;
    end else begin
      mul_sat = WMAX;
    end
  end

  assign base = ctrl_i.use_mul ? mul_sat : a_i;
  assign sum  = {base[WORD_W-1], base} + {x_i[WORD_W-1], x_i};
  assign diff = {base[WORD_W-1], base} - {x_i[WORD_W-1], x_i};

  always_comb begin
    case (ctrl_i.post)
      POST_NONE: res_o = base;
      POST_NEG:  res_o = (base == WMIN) ? WMAX : -base;
      POST_ADDX: begin
        if (sum[WORD_W] != sum[WORD_W-1]) begin
          res_o = sum[WORD_W] ? WMIN : WMAX;
        end else begin
          res_o = sum[WORD_W-1:0];
        end
      end
      POST_SUBX: begin
        if (diff[WORD_W] != diff[WORD_W-1]) begin
          res_o = diff[WORD_W] ? WMIN : WMAX;
        end else begin
          res_o = diff[WORD_W-1:0];
        end
      end
      default: res_o = base;
    endcase
  end

endmodule

`default_nettype wire

@@ src/quadrotor_euler_step.sv @@
`default_nettype none

// One request is one integration tick of the 12-word body state (position, velocity,
// roll/pitch/yaw angles and rates), which lives in a small single-port-read RAM. A tick
// runs as a fixed list of operations on one shared 32x32 multiplier with a saturating
// adder, each operation a multiply phase and then a scale-and-write-back phase, with the RAM
// read for the next operation issued during the write-back of the current one. The
// finished state is then read out of the RAM into the output register, one word a
// cycle. A motor-thrust tick (kind 0) runs 29 operations and a direct force/torque tick
// (kind 1) runs 15 operations. The next request is taken once the read-out is done,
// even while the previous result still waits at the output. Write configuration only
// while idle; the registers are read live by the operations that use them.
module quadrotor_euler_step #(
  parameter int unsigned FRAC_BITS = qes_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // motor_thrust_0..3, force_x, force_y, lift_thrust, roll_torque, pitch_torque, yaw_torque
  input  wire logic [qes_pkg::NUM_FIELDS*qes_pkg::WORD_W-1:0] s_axis_tdata,
  // kind
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, roll_angle, pitch_angle, yaw_angle,
  // roll_rate, pitch_rate, yaw_rate
  output logic [qes_pkg::NUM_WORDS*qes_pkg::WORD_W-1:0] m_axis_tdata,
  input  wire logic                              cfg_we_i,
  input  wire logic [qes_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [qes_pkg::CFG_W-1:0]         cfg_data_i
);

  import qes_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_DUMP = 3'd3;
  localparam logic [2:0] ST_FILL = 3'd4;

  logic [2:0]               state_q, state_d;
  logic                     phase_q, phase_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [ADDR_W-1:0]        cnt_q, cnt_d;
  logic                     cap_v_q, cap_v_d;
  logic [ADDR_W-1:0]        cap_idx_q, cap_idx_d;
  logic                     out_valid_q, out_valid_d;
  logic [NUM_WORDS-1:0]     vld_q, vld_d;
  logic                     rvld_q;
  logic                     kind_q;
  logic signed [WORD_W-1:0] fld_q [NUM_FIELDS];
  logic signed [WORD_W-1:0] tmp_q [NUM_TEMPS];
  logic signed [WORD_W-1:0] tmp_d [NUM_TEMPS];
  logic signed [WORD_W-1:0] res_q, res_d;
  logic [WORD_W-1:0]        out_q [NUM_WORDS];

  logic [CFG_W-1:0] dt_q, grav_q, imass_q, iiner_q, arm_q, drag_q;

  uop_t                     uop_cur, uop_nxt, uop_first;
  logic                     accept;
  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic signed [WORD_W-1:0] ram_word;
  logic signed [WORD_W-1:0] srcv [NUM_SRC];
  logic signed [WORD_W-1:0] mac_res;
  mac_ctrl_t                mac_ctrl;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

  assign uop_cur   = uop_lookup(kind_q, step_q);
  assign uop_nxt   = uop_lookup(kind_q, STEP_W'(step_q + 1'b1));
  assign uop_first = uop_lookup(s_axis_tuser, '0);

  assign ram_word = rvld_q ? $signed(ram_rdata) : '0;

  always_comb begin
    srcv[SRC_ZERO]  = '0;
    srcv[SRC_RAM]   = ram_word;
    srcv[SRC_RES]   = res_q;
    srcv[SRC_T0]    = tmp_q[0];
    srcv[SRC_T1]    = tmp_q[1];
    srcv[SRC_T2]    = tmp_q[2];
    srcv[SRC_T3]    = tmp_q[3];
    srcv[SRC_F0]    = fld_q[0];
    srcv[SRC_F1]    = fld_q[1];
    srcv[SRC_F2]    = fld_q[2];
    srcv[SRC_F3]    = fld_q[3];
    srcv[SRC_F4]    = fld_q[4];
    srcv[SRC_F5]    = fld_q[5];
    srcv[SRC_F6]    = fld_q[6];
    srcv[SRC_F7]    = fld_q[7];
    srcv[SRC_F8]    = fld_q[8];
    srcv[SRC_F9]    = fld_q[9];
    srcv[SRC_DT]    = $signed({1'b0, dt_q});
    srcv[SRC_GRAV]  = $signed({1'b0, grav_q});
    srcv[SRC_IMASS] = $signed({1'b0, imass_q});
    srcv[SRC_IINER] = $signed({1'b0, iiner_q});
    srcv[SRC_ARM]   = $signed({1'b0, arm_q});
    srcv[SRC_DRAG]  = $signed({1'b0, drag_q});
  end

  qes_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .ctrl_i(mac_ctrl),
    .a_i   (srcv[uop_cur.a]),
    .b_i   (srcv[uop_cur.b]),
    .x_i   (srcv[uop_cur.x]),
    .res_o (mac_res)
  );

  qes_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(mac_res),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    cap_v_d      = 1'b0;
    cap_idx_d    = cap_idx_q;
    out_valid_d  = out_valid_q;
    vld_d        = vld_q;
    tmp_d        = tmp_q;
    res_d        = res_q;
    ram_we       = 1'b0;
    ram_waddr    = uop_cur.addr;
    ram_re       = 1'b0;
    ram_raddr    = uop_nxt.addr;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.use_mul = uop_cur.mul;
    mac_ctrl.post    = uop_cur.post;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ram_re    = 1'b1;
          ram_raddr = uop_first.addr;
          step_d    = '0;
          phase_d   = 1'b0;
          state_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!phase_q) begin
          mac_ctrl.mul_en = uop_cur.mul;
          phase_d         = 1'b1;
        end else begin
          res_d  = mac_res;
          ram_re = 1'b1;
          case (uop_cur.dst)
            DST_T0:  tmp_d[0] = mac_res;
            DST_T1:  tmp_d[1] = mac_res;
            DST_T2:  tmp_d[2] = mac_res;
            DST_T3:  tmp_d[3] = mac_res;
            DST_RAM: begin
              ram_we               = 1'b1;
              vld_d[uop_cur.addr]  = 1'b1;
            end
            default: ;
          endcase
          phase_d = 1'b0;
          if (uop_cur.last) begin
            cnt_d   = '0;
            state_d = out_valid_q ? ST_WAIT : ST_DUMP;
          end else begin
            step_d = STEP_W'(step_q + 1'b1);
          end
        end
      end
      ST_WAIT: begin
        if (!out_valid_q) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
        cap_v_d   = 1'b1;
        cap_idx_d = cnt_q;
        cnt_d     = ADDR_W'(cnt_q + 1'b1);
        if (cnt_q == ADDR_W'(NUM_WORDS - 1)) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      step_q      <= '0;
      cnt_q       <= '0;
      cap_v_q     <= 1'b0;
      cap_idx_q   <= '0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      rvld_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      cap_v_q     <= cap_v_d;
      cap_idx_q   <= cap_idx_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
      if (ram_re) begin
        rvld_q <= vld_q[ram_raddr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= RST_TIME_STEP;
      grav_q  <= RST_GRAVITY;
      imass_q <= RST_INV_MASS;
      iiner_q <= RST_INV_INER;
      arm_q   <= RST_ARM;
      drag_q  <= RST_DRAG;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIME_STEP: dt_q    <= cfg_data_i;
        CFG_GRAVITY:   grav_q  <= cfg_data_i;
        CFG_INV_MASS:  imass_q <= cfg_data_i;
        CFG_INV_INER:  iiner_q <= cfg_data_i;
        CFG_ARM:       arm_q   <= cfg_data_i;
        CFG_DRAG:      drag_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tuser;
      for (int i = 0; i < NUM_FIELDS; i++) begin
        fld_q[i] <= $signed(s_axis_tdata[i*WORD_W +: WORD_W]);
      end
    end
    tmp_q <= tmp_d;
    res_q <= res_d;
    if (cap_v_q) begin
      out_q[cap_idx_q] <= ram_word;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      m_axis_tdata[i*WORD_W +: WORD_W] = out_q[i];
    end
  end

endmodule

`default_nettype wire
